// File: rtl/smsu_pkg.sv
// ----------------------------------------------------------------------------
// smsu_pkg
// Shared types, constants and helpers for the SMS septet unpacker.
// ----------------------------------------------------------------------------
package smsu_pkg;

	// command queue between the front and back halves
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	// result queue at the back end
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	localparam logic [2:0] PHASE_WRAP = 3'd6;
	localparam logic [7:0] COUNT_MAX  = 8'd255;

	localparam logic [7:0] CHAR_0  = 8'h30;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LF = 8'h66;
	localparam logic [7:0] HEX_TEN = 8'd10;

	localparam logic [6:0] LOW_MASKS [7] = '{7'd1, 7'd3, 7'd7, 7'd15, 7'd31, 7'd63, 7'd127};

	// one command from front to back: a full octet or an end marker
	typedef struct packed {
		logic       is_end;
		logic [7:0] octet;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic [6:0] septet;
		logic [7:0] count;
		logic       last;
	} res_t;

	function automatic logic [7:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		case (c) inside
			[CHAR_UA:CHAR_UF]: v = c - CHAR_UA + HEX_TEN;
			[CHAR_LA:CHAR_LF]: v = c - CHAR_LA + HEX_TEN;
			default:           v = c - CHAR_0;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] low_mask(input logic [2:0] phase);
		logic [2:0] idx;
		idx = PHASE_WRAP - phase;
		return LOW_MASKS[idx];
	endfunction

endpackage

// File: rtl/smsu_front.sv
// ----------------------------------------------------------------------------
// smsu_front
// Pairs hex characters into octets and classifies end-of-message beats.
// ----------------------------------------------------------------------------
module smsu_front
	import smsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] hex_char,
	input  logic       end_of_text,
	output logic       full,
	output logic       cmd_push,
	output cmd_t       cmd_data,
	input  logic       cmd_full
);

	logic [7:0] high_q;
	logic       have_high_q;
	logic       accept;
	logic [7:0] nib;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign nib    = hex_value(hex_char);

	// second char of a pair or an end marker produces a command
	assign cmd_push        = accept && (end_of_text || have_high_q);
	assign cmd_data.is_end = end_of_text;
	assign cmd_data.octet  = {high_q[3:0], 4'b0000} + nib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_high_q <= 1'b0;
			high_q      <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				// unpaired trailing char is dropped
				have_high_q <= 1'b0;
				high_q      <= '0;
			end else if (!have_high_q) begin
				have_high_q <= 1'b1;
				high_q      <= nib;
			end else begin
				have_high_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/smsu_cmd_queue.sv
// ----------------------------------------------------------------------------
// smsu_cmd_queue
// Short FIFO of commands that decouples the front from the back.
// ----------------------------------------------------------------------------
module smsu_cmd_queue
	import smsu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic q_valid
);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == CQ_AW'(0) + (CQ_AW+1)'(CQ_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/smsu_back.sv
// ----------------------------------------------------------------------------
// smsu_back
// Unpacks octets into septets and queues result beats for the consumer.
// ----------------------------------------------------------------------------
module smsu_back
	import smsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd_data,
	input  logic       cmd_valid,
	output logic       cmd_pop,
	input  logic       pop,
	output logic       empty,
	output logic [6:0] septet_char,
	output logic [7:0] char_count,
	output logic       last
);

	// unpack state
	logic [2:0] phase_q;
	logic [6:0] carry_q;
	logic [7:0] count_q;
	logic       second_q;   // wrap septet still owed

	// result queue
	res_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] oq_wr_q;
	logic [OQ_AW-1:0] oq_rd_q;
	logic [OQ_AW:0]   oq_cnt_q;
	logic             oq_full;
	logic             oq_wr;
	logic             oq_rd;

	logic [2:0] phase;
	logic [6:0] mask;
	logic [7:0] shifted;
	logic [7:0] hi_bits;
	logic [6:0] ch;
	logic [6:0] carry_nxt;
	logic [7:0] count_inc;
	res_t       res;

	assign oq_full = (oq_cnt_q == (OQ_AW+1)'(OQ_DEPTH));
	assign empty   = (oq_cnt_q == '0);
	assign oq_rd   = pop && !empty;

	assign {septet_char, char_count, last} = oq_q[oq_rd_q];

	assign cmd_pop = cmd_valid && !second_q && !oq_full;
	assign oq_wr   = !oq_full && (second_q || cmd_valid);

	always_comb begin
		phase     = (phase_q > PHASE_WRAP) ? PHASE_WRAP : phase_q;
		mask      = low_mask(phase);
		shifted   = ({1'b0, cmd_data.octet[6:0] & mask}) << phase;
		ch        = shifted[6:0] + carry_q;
		hi_bits   = (cmd_data.octet & ~{1'b0, mask}) >> (3'd7 - phase);
		carry_nxt = hi_bits[6:0];
		count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
	end

	always_comb begin
		if (second_q) begin
			res = '{septet: carry_q, count: count_inc, last: 1'b0};
		end else if (cmd_data.is_end) begin
			res = '{septet: '0, count: count_q, last: 1'b1};
		end else begin
			res = '{septet: ch, count: count_inc, last: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (oq_wr) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			carry_q  <= '0;
			count_q  <= '0;
			second_q <= 1'b0;
		end else if (oq_wr) begin
			if (second_q) begin
				second_q <= 1'b0;
				carry_q  <= '0;
				count_q  <= count_inc;
			end else if (cmd_data.is_end) begin
				phase_q <= '0;
				carry_q <= '0;
				count_q <= '0;
			end else begin
				count_q <= count_inc;
				carry_q <= carry_nxt;
				if (phase == PHASE_WRAP) begin
					phase_q  <= '0;
					second_q <= 1'b1;
				end else begin
					phase_q <= phase + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_wr) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_rd) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({oq_wr, oq_rd})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= (OQ_AW+1)'(OQ_DEPTH))
		else $error("result queue count overflow");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_WRAP)
		else $error("shift phase out of range");

	a_wrap_phase: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (phase_q == '0) && !cmd_pop)
		else $error("wrap septet owed with nonzero phase or command pop");

	a_wrap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(second_q && !oq_full) |=> !second_q)
		else $error("wrap septet not retired");

endmodule

// File: rtl/sms_septet_unpacker_unit.sv
// ----------------------------------------------------------------------------
// sms_septet_unpacker_unit
// GSM 7-bit septet unpacker: hex character beats in, septet beats out.
// ----------------------------------------------------------------------------
// Path: a completing character or end beat is written into the command queue,
// then the back end writes its result beat into the output queue to be popped.
// Throughput: one character beat per cycle while full is low; the back end pops
// one command per cycle when its queue has room and no wrap septet is owed.
// Reset: arst_n clears pairing, phase, carry, count and both queues at once.
// ----------------------------------------------------------------------------
module sms_septet_unpacker_unit
	import smsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input side
	input  logic       push,
	output logic       full,
	input  logic [7:0] hex_char,
	input  logic       end_of_text,
	// result side
	output logic       empty,
	input  logic       pop,
	output logic [6:0] septet_char,
	output logic [7:0] char_count,
	output logic       last
);

	// front -> queue
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_full;
	// queue -> back
	cmd_t cmd_out;
	logic cmd_valid;
	logic cmd_pop;

	// The front half pairs characters into octets; the first char of a pair
	// only updates the stored nibble. Completed octets and end markers go
	// into a small command queue so that a stalled consumer does not stop
	// character intake until the queue fills.
	smsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.hex_char    (hex_char),
		.end_of_text (end_of_text),
		.full        (full),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_in),
		.cmd_full    (cmd_full)
	);

	smsu_cmd_queue u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.q_full  (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.q_valid (cmd_valid)
	);

	// The back half holds phase, carry and the saturating count, and writes
	// result beats into its own output queue. At phase 6 the octet yields a
	// second septet from the carry, written as the next result beat.
	smsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_data    (cmd_out),
		.cmd_valid   (cmd_valid),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.septet_char (septet_char),
		.char_count  (char_count),
		.last        (last)
	);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sms_septet_unpacker_unit. Sends hex character beats and end
// beats, predicts every septet and end beat, and checks each popped beat
// field by field against the oldest predicted one. Both sides stall at
// random, with the idle rates swapped midway; the last run has no stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import smsu_pkg::*;

	// one predicted result beat
	typedef struct {
		logic [6:0] septet;
		logic [7:0] count;
		logic       last;
	} septet_beat_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       push        = 1'b0;
	logic [7:0] hex_char    = 8'h00;
	logic       end_of_text = 1'b0;
	logic       pop         = 1'b0;
	logic       full;
	logic       empty;
	logic [6:0] septet_char;
	logic [7:0] char_count;
	logic       last;

	// predictor state: pending high nibble, packing phase, carry, count
	logic [7:0] pend_nibble;
	logic       pend_valid;
	logic [2:0] pack_phase;
	logic [6:0] pack_carry;
	logic [7:0] emit_count;

	septet_beat_t expected_beats[$];
	int           error_count   = 0;
	int           beats_sent    = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	sms_septet_unpacker_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.hex_char    (hex_char),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.septet_char (septet_char),
		.char_count  (char_count),
		.last        (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		if (c >= CHAR_UA && c <= CHAR_UF)
			return c - CHAR_UA + HEX_TEN;
		if (c >= CHAR_LA && c <= CHAR_LF)
			return c - CHAR_LA + HEX_TEN;
		// anything else wraps: (code - '0') mod 256
		return c - CHAR_0;
	endfunction

	task automatic clear_unpack_state();
		pend_nibble = '0;
		pend_valid  = 1'b0;
		pack_phase  = '0;
		pack_carry  = '0;
		emit_count  = '0;
	endtask

	task automatic queue_septet(input logic [6:0] ch);
		septet_beat_t b;
		if (emit_count != COUNT_MAX)
			emit_count = emit_count + 8'd1;
		b.septet = ch;
		b.count  = emit_count;
		b.last   = 1'b0;
		expected_beats.push_back(b);
	endtask

	task automatic predict_septets(input logic [7:0] c, input logic eot);
		septet_beat_t b;
		logic [7:0]   octet;
		logic [7:0]   mask;
		logic [2:0]   ph;
		logic [15:0]  shifted;
		if (eot) begin
			// end beat: final count, then everything back to zero
			b.septet = '0;
			b.count  = emit_count;
			b.last   = 1'b1;
			expected_beats.push_back(b);
			clear_unpack_state();
			return;
		end
		if (!pend_valid) begin
			pend_nibble = nibble_of(c);
			pend_valid  = 1'b1;
			return;
		end
		pend_valid = 1'b0;
		octet   = {pend_nibble[3:0], 4'h0} + nibble_of(c);
		ph      = (pack_phase > PHASE_WRAP) ? PHASE_WRAP : pack_phase;
		mask    = 8'h7F >> ph;
		shifted = {8'h00, octet & mask} << ph;
		queue_septet(shifted[6:0] + pack_carry);
		pack_carry = 7'((octet & ~mask) >> (7 - ph));
		if (ph == PHASE_WRAP) begin
			// phase wrap: the carry holds a whole septet of its own
			queue_septet(pack_carry);
			pack_carry = '0;
			pack_phase = '0;
		end else begin
			pack_phase = ph + 3'd1;
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random pop, checked at every accepted beat
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		septet_beat_t want;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: septet_char=%0h char_count=%0d last=%0b",
					septet_char, char_count, last);
				error_count++;
			end else begin
				want = expected_beats.pop_front();
				if (septet_char !== want.septet) begin
					$error("septet_char: expected %0h, got %0h", want.septet, septet_char);
					error_count++;
				end
				if (char_count !== want.count) begin
					$error("char_count: expected %0d, got %0d", want.count, char_count);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// one input beat; push stays high into the next call unless it idles
	task automatic send_beat(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		hex_char    <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_septets(c, eot);
		beats_sent++;
	endtask

	// hold the input off until every predicted beat has been popped
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return CHAR_0 + 8'(v);
		return ($urandom_range(1) ? CHAR_UA : CHAR_LA) + 8'(v - 10);
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// end beat straight after reset: count 0, last set
	task automatic test_empty_message();
		send_beat(8'hFF, 1'b1);
	endtask

	// seven octets walk phase 0..6 and wrap; mixed case, digits, extremes;
	// a trailing unpaired character must be dropped at the end beat
	task automatic test_full_wrap_cycle();
		send_beat("F", 1'b0); send_beat("F", 1'b0);
		send_beat("0", 1'b0); send_beat("0", 1'b0);
		send_beat("a", 1'b0); send_beat("B", 1'b0);
		send_beat("c", 1'b0); send_beat("D", 1'b0);
		send_beat("e", 1'b0); send_beat("f", 1'b0);
		send_beat("9", 1'b0); send_beat("8", 1'b0);
		send_beat("E", 1'b0); send_beat("7", 1'b0);
		send_beat("G", 1'b0);
		send_beat(8'h00, 1'b1);
	endtask

	// characters outside the hex set wrap through (code - '0')
	task automatic test_non_hex_chars();
		send_beat(8'h00, 1'b0); send_beat(8'hFF, 1'b0);
		send_beat("g", 1'b0);   send_beat("@", 1'b0);
		send_beat(8'hFF, 1'b1);
	endtask

	// one long message: the count must stick at its maximum
	task automatic test_count_saturation();
		repeat (600)
			send_beat(random_hex_char(), 1'b0);
		send_beat(8'($urandom_range(255)), 1'b1);
	endtask

	// mostly well-formed messages, some noise bytes and odd lengths
	task automatic test_random_messages(input int n_beats);
		int start;
		int pairs;
		int kind;
		start = beats_sent;
		while (beats_sent - start < n_beats) begin
			pairs = $urandom_range(20);
			kind  = $urandom_range(9);
			repeat (2 * pairs) begin
				if (kind == 0)
					send_beat(8'($urandom_range(255)), 1'b0);
				else
					send_beat(random_hex_char(), 1'b0);
			end
			if (kind == 1)
				send_beat(random_hex_char(), 1'b0);
			send_beat(8'($urandom_range(255)), 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int waited;
		clear_unpack_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 57;
		test_empty_message();
		test_full_wrap_cycle();
		test_non_hex_chars();
		drain_results();

		test_random_messages(220);
		drain_results();

		send_idle_pct = 57;
		recv_idle_pct = 30;
		test_random_messages(220);
		drain_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_count_saturation();
		test_random_messages(100);

		push <= 1'b0;
		waited = 0;
		while (expected_beats.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		// keep clocking to catch any stray beat
		repeat (10) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d predicted beats never arrived", expected_beats.size());
			error_count++;
		end
		if (error_count == 0)
			$display("PASS sms_septet_unpacker_unit");
		else
			$display("FAIL sms_septet_unpacker_unit");
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL sms_septet_unpacker_unit");
		$finish;
	end

endmodule
